// ===== hdl/vfm_pkg.sv =====
package vfm_pkg;

	// Sample and pixel widths
	localparam int SAMPLE_W = 8;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// Reset value of the width and height registers
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 10'd512;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		MODE_UP    = 2'd0,
		MODE_DOWN  = 2'd1,
		MODE_LEFT  = 2'd2,
		MODE_RIGHT = 2'd3
	} mirror_mode_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] luma;
		logic [SAMPLE_W-1:0] blue_diff;
		logic [SAMPLE_W-1:0] red_diff;
	} pixel_t;

endpackage

// ===== hdl/vfm_ifs.sv =====
interface vfm_in_if;
	logic                         valid;
	logic                         ready;
	logic [vfm_pkg::SAMPLE_W-1:0] luma_in;
	logic [vfm_pkg::SAMPLE_W-1:0] blue_diff_in;
	logic [vfm_pkg::SAMPLE_W-1:0] red_diff_in;

	modport source(output valid, output luma_in, output blue_diff_in, output red_diff_in,
		input ready);
	modport sink(input valid, input luma_in, input blue_diff_in, input red_diff_in,
		output ready);
endinterface

interface vfm_out_if;
	logic                         valid;
	logic                         ready;
	logic [vfm_pkg::SAMPLE_W-1:0] luma_out;
	logic [vfm_pkg::SAMPLE_W-1:0] blue_diff_out;
	logic [vfm_pkg::SAMPLE_W-1:0] red_diff_out;
	logic                         pixel_valid;
	logic                         frame_end;

	modport source(output valid, output luma_out, output blue_diff_out,
		output red_diff_out, output pixel_valid, output frame_end, input ready);
	modport sink(input valid, input luma_out, input blue_diff_out,
		input red_diff_out, input pixel_valid, input frame_end, output ready);
endinterface

interface vfm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [vfm_pkg::CFG_IDX_W-1:0]  index;
	logic [vfm_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hdl/vfm_addr.sv =====
module vfm_addr #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  vfm_pkg::mirror_mode_t               mode,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]      w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]     h,
	input  logic [$clog2(MAX_WIDTH)-1:0]        x,
	input  logic [$clog2(MAX_HEIGHT)-1:0]       y,
	output logic [$clog2(MAX_WIDTH)-1:0]        sx,
	output logic [$clog2(MAX_HEIGHT)-1:0]       sy
);
	import vfm_pkg::*;

	localparam int XB = $clog2(MAX_WIDTH);
	localparam int YB = $clog2(MAX_HEIGHT);
	localparam int WB = $clog2(MAX_WIDTH+1);
	localparam int HB = $clog2(MAX_HEIGHT+1);

	logic [WB-1:0] hw;
	logic [HB-1:0] hh;
	logic [WB-1:0] xw;
	logic [HB-1:0] yh;
	logic [HB-1:0] y_flip;
	logic [WB-1:0] x_flip;
	logic [WB-1:0] x_shift;
	logic [WB-1:0] x_fold;

	// Half sizes and the reflected coordinates
	assign hw      = w >> 1;
	assign hh      = h >> 1;
	assign xw      = WB'(x);
	assign yh      = HB'(y);
	assign y_flip  = h - HB'(1) - yh;
	assign x_flip  = w - WB'(1) - xw;
	assign x_shift = xw + hw;
	assign x_fold  = x_flip + hw;

	// Pick the source position for the selected mirror direction
	always_comb begin
		sx = x;
		sy = y;
		unique case (mode)
			MODE_UP: begin
				if (yh >= hh) sy = y_flip[YB-1:0];
			end
			MODE_DOWN: begin
				if (yh < hh) sy = y_flip[YB-1:0];
			end
			MODE_LEFT: begin
				if (xw < hw) sx = x_flip[XB-1:0];
			end
			MODE_RIGHT: begin
				if (xw < hw) sx = x_shift[XB-1:0];
				else         sx = x_fold[XB-1:0];
			end
			default: begin
				sx = x;
				sy = y;
			end
		endcase
	end

endmodule

// ===== hdl/video_frame_mirror.sv =====
// Pipeline: a pixel accepted on the input is registered with its frame store read in
// stage s1, then in the output register, where it is held while the output stalls.
// Throughput: one pixel per cycle while the output is ready; the frame store has one write port and one
// registered read port, the two banks never collide, so no interlock is needed.
// Reset: counters, bank select, first-frame flag and handshakes clear at once;
// the frame store is not cleared, its contents are masked until a frame is stored.
module video_frame_mirror #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512
) (
	input  logic clk,
	input  logic arst_n,
	vfm_cfg_if.sink   cfg,
	vfm_in_if.sink    pix_in,
	vfm_out_if.source pix_out
);
	import vfm_pkg::*;

	localparam int XB    = $clog2(MAX_WIDTH);
	localparam int YB    = $clog2(MAX_HEIGHT);
	localparam int WB    = $clog2(MAX_WIDTH+1);
	localparam int HB    = $clog2(MAX_HEIGHT+1);
	localparam int CWB   = (WB > CFG_DATA_W) ? WB : CFG_DATA_W;
	localparam int CHB   = (HB > CFG_DATA_W) ? HB : CFG_DATA_W;
	localparam int AW    = 1 + YB + XB;
	localparam int DEPTH = 2 ** AW;

	// Configuration registers
	mirror_mode_t          mode_q;
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;

	// Raster position and frame bookkeeping
	logic [XB-1:0] x_q;
	logic [YB-1:0] y_q;
	logic          bank_q;
	logic          seen_q;

	// Pipeline
	logic   valid_s1;
	logic   seen_s1;
	logic   last_s1;
	pixel_t rd_s1;
	logic   out_valid_q;
	pixel_t out_pix_q;
	logic   out_seen_q;
	logic   out_last_q;

	pixel_t mem [DEPTH];

	logic          cfg_wr;
	logic          restart;
	logic          in_acc;
	logic          adv1;
	logic [CWB-1:0] w_wide;
	logic [CHB-1:0] h_wide;
	logic [WB-1:0] w_eff;
	logic [HB-1:0] h_eff;
	logic          x_last;
	logic          y_last;
	logic [XB-1:0] sx;
	logic [YB-1:0] sy;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	pixel_t        pix;

	// Handshakes
	assign cfg.ready    = 1'b1;
	assign cfg_wr       = cfg.valid & cfg.ready;
	assign restart      = cfg_wr & ((cfg.index == REG_WIDTH) || (cfg.index == REG_HEIGHT));
	assign adv1         = valid_s1 & (~out_valid_q | pix_out.ready);
	assign pix_in.ready = ~valid_s1 | adv1;
	assign in_acc       = pix_in.valid & pix_in.ready;

	// Clamp the frame size to the supported range
	assign w_wide = CWB'(width_q);
	assign h_wide = CHB'(height_q);

	always_comb begin
		if (w_wide == '0)                  w_eff = WB'(1);
		else if (w_wide > CWB'(MAX_WIDTH)) w_eff = WB'(MAX_WIDTH);
		else                               w_eff = w_wide[WB-1:0];
		if (h_wide == '0)                   h_eff = HB'(1);
		else if (h_wide > CHB'(MAX_HEIGHT)) h_eff = HB'(MAX_HEIGHT);
		else                                h_eff = h_wide[HB-1:0];
	end

	assign x_last = (WB'(x_q) == w_eff - WB'(1));
	assign y_last = (HB'(y_q) == h_eff - HB'(1));

	vfm_addr #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_addr (
		.mode(mode_q),
		.w   (w_eff),
		.h   (h_eff),
		.x   (x_q),
		.y   (y_q),
		.sx  (sx),
		.sy  (sy)
	);

	assign wr_addr = {bank_q, y_q, x_q};
	assign rd_addr = {~bank_q, sy, sx};
	assign pix     = '{luma: pix_in.luma_in, blue_diff: pix_in.blue_diff_in,
		red_diff: pix_in.red_diff_in};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_UP;
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				REG_MODE:   mode_q   <= mirror_mode_t'(cfg.data[1:0]);
				REG_WIDTH:  width_q  <= cfg.data;
				REG_HEIGHT: height_q <= cfg.data;
				default:    ;
			endcase
		end
	end

	// Advance the raster position; swap banks at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			bank_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (restart) begin
			x_q    <= '0;
			y_q    <= '0;
			seen_q <= 1'b0;
		end else if (in_acc) begin
			if (x_last) begin
				x_q <= '0;
				if (y_last) begin
					y_q    <= '0;
					bank_q <= ~bank_q;
					seen_q <= 1'b1;
				end else begin
					y_q <= y_q + YB'(1);
				end
			end else begin
				x_q <= x_q + XB'(1);
			end
		end
	end

	// Frame store: write the current bank, read the previous one
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mem[wr_addr] <= pix;
			rd_s1        <= mem[rd_addr];
			seen_s1      <= seen_q;
			last_s1      <= x_last & y_last;
		end
	end

	// Stage valid behind the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc)    valid_s1 <= 1'b1;
			else if (adv1) valid_s1 <= 1'b0;
			if (adv1)               out_valid_q <= 1'b1;
			else if (pix_out.ready) out_valid_q <= 1'b0;
		end
	end

	// Output register; mask data until a full frame is stored
	always_ff @(posedge clk) begin
		if (adv1) begin
			out_pix_q  <= seen_s1 ? rd_s1 : '0;
			out_seen_q <= seen_s1;
			out_last_q <= last_s1;
		end
	end

	assign pix_out.valid         = out_valid_q;
	assign pix_out.luma_out      = out_pix_q.luma;
	assign pix_out.blue_diff_out = out_pix_q.blue_diff;
	assign pix_out.red_diff_out  = out_pix_q.red_diff;
	assign pix_out.pixel_valid   = out_seen_q;
	assign pix_out.frame_end     = out_last_q;

endmodule
